/* hw/rtl/spa_pkg.sv */
// Shared types and constants for the sparse polynomial unit.
package spa_pkg;
  localparam int CoefW = 16;
  localparam int ExpW  = 8;
  localparam int AccW  = 38;
  localparam int PexpW = 9;
  localparam int ProdDepth = 64;
  localparam int PcntW = 7;

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_MUL,
    ST_DRAIN,
    ST_ZERO
  } state_t;

  // one control word broadcast to every cell of the product chain
  typedef struct packed {
    logic             ins;
    logic [AccW-1:0]  coef;
    logic [PexpW-1:0] exp;
  } prod_req_t;
endpackage

/* hw/rtl/spa_cell.sv */
// One cell of the sorted product chain.
module spa_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  logic                   shift_out,
  input  logic                   add_en,
  input  spa_pkg::prod_req_t     req,
  input  logic                   prev_valid,
  input  logic [spa_pkg::AccW-1:0]  prev_coef,
  input  logic [spa_pkg::PexpW-1:0] prev_exp,
  input  logic                   prev_ge,
  input  logic                   next_valid,
  input  logic [spa_pkg::AccW-1:0]  next_coef,
  input  logic [spa_pkg::PexpW-1:0] next_exp,
  input  logic                   next_zero_here,
  output logic                   valid,
  output logic [spa_pkg::AccW-1:0]  coef,
  output logic [spa_pkg::PexpW-1:0] exp,
  output logic                   ge,
  output logic                   zero_here
);
  import spa_pkg::*;
  logic             valid_r, valid_nxt;
  logic [AccW-1:0]  coef_r, coef_nxt, sum;
  logic [PexpW-1:0] exp_r, exp_nxt;
  logic             hit, above, push, take;

  assign sum   = coef_r + req.coef;
  assign hit   = valid_r && exp_r == req.exp;
  assign above = valid_r && exp_r > req.exp;
  // ge: this cell and all before hold exponent >= request
  assign ge        = above || hit;
  assign zero_here = hit && sum == '0;
  assign push = add_en && req.ins && !ge && prev_ge;
  assign take = add_en && req.ins && !ge && !prev_ge;

  always_comb begin
    valid_nxt = valid_r;
    coef_nxt  = coef_r;
    exp_nxt   = exp_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (shift_out) begin
      valid_nxt = next_valid;
      coef_nxt  = next_coef;
      exp_nxt   = next_exp;
    end else if (add_en && !req.ins && hit && !zero_here) begin
      coef_nxt = sum;
    end else if (add_en && !req.ins && (zero_here || (next_zero_here && !ge))) begin
      valid_nxt = next_valid;
      coef_nxt  = next_coef;
      exp_nxt   = next_exp;
    end else if (push) begin
      valid_nxt = 1'b1;
      coef_nxt  = req.coef;
      exp_nxt   = req.exp;
    end else if (take) begin
      valid_nxt = prev_valid;
      coef_nxt  = prev_coef;
      exp_nxt   = prev_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    coef_r <= coef_nxt;
    exp_r  <= exp_nxt;
  end

  assign valid = valid_r;
  assign coef  = coef_r;
  assign exp   = exp_r;
endmodule

/* hw/rtl/sparse_polynomial_arithmetic_unit.sv */
// Top level of the sparse polynomial add, subtract and multiply unit.
//  channel | ports                                   | handshake
//  request | in_opcode, in_term_coef, in_term_exp    | start && !busy
//  result  | out_result_coef .. out_load_error       | out_strobe, one cycle
// Loads and clear never leave the idle state. Add and subtract take
// one merged step per cycle. Multiply feeds each A*B term product
// into the product chain, then drains one output term per cycle.
// Reset is synchronous and empties both operands and the chain.
// Results are never held off; only busy stalls new requests.
module sparse_polynomial_arithmetic_unit #(
  parameter int MAX_TERMS    = 8,
  parameter int MAX_EXPONENT = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_opcode,
  input  logic signed [15:0]          in_term_coef,
  input  logic [7:0]                  in_term_exp,
  output logic                        out_strobe,
  output logic signed [37:0]          out_result_coef,
  output logic [8:0]                  out_result_exp,
  output logic                        out_term_valid,
  output logic                        out_last_term,
  output logic                        out_load_error
);
  import spa_pkg::*;
  localparam int IdxW  = $clog2(MAX_TERMS + 1);
  localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int N = ProdDepth;

  logic [CoefW-1:0] a_coefs [MAX_TERMS];
  logic [ExpW-1:0]  a_exps  [MAX_TERMS];
  logic [CoefW-1:0] b_coefs [MAX_TERMS];
  logic [ExpW-1:0]  b_exps  [MAX_TERMS];
  logic [IdxW-1:0]  a_cnt_r, b_cnt_r, i_r, i_nxt, j_r, j_nxt;
  logic [IdxW-1:0]  a_prev, b_prev;
  logic             err_r, err_nxt, sub_r, sub_nxt;
  state_t           st_r, st_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic [AccW-1:0]  hold_coef_r, hold_coef_nxt;
  logic [PexpW-1:0] hold_exp_r, hold_exp_nxt;

  logic             acc;
  logic             ld_a, ld_b, ld_bad_a, ld_bad_b;
  assign acc = start && !busy;
  assign busy = st_r != ST_IDLE;

  function automatic logic bad_load(input logic [IdxW-1:0] cnt,
                                    input logic [ExpW-1:0] last);
    bad_load = (cnt >= IdxW'(MAX_TERMS)) ||
               ({24'd0, in_term_exp} > 32'(MAX_EXPONENT)) ||
               (cnt != '0 && in_term_exp >= last);
  endfunction

  logic [ExpW-1:0] a_last, b_last;
  assign a_prev = a_cnt_r - IdxW'(1);
  assign b_prev = b_cnt_r - IdxW'(1);
  assign a_last = (a_cnt_r == '0) ? '0 : a_exps[a_prev[AddrW-1:0]];
  assign b_last = (b_cnt_r == '0) ? '0 : b_exps[b_prev[AddrW-1:0]];
  assign ld_bad_a = bad_load(a_cnt_r, a_last);
  assign ld_bad_b = bad_load(b_cnt_r, b_last);
  assign ld_a = acc && in_opcode == OP_LOAD_A && !ld_bad_a && in_term_coef != '0;
  assign ld_b = acc && in_opcode == OP_LOAD_B && !ld_bad_b && in_term_coef != '0;

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_coefs[a_cnt_r[AddrW-1:0]] <= in_term_coef;
      a_exps[a_cnt_r[AddrW-1:0]]  <= in_term_exp;
    end
    if (ld_b) begin
      b_coefs[b_cnt_r[AddrW-1:0]] <= in_term_coef;
      b_exps[b_cnt_r[AddrW-1:0]]  <= in_term_exp;
    end
  end

  // merge / product datapath
  logic             ia, jb;
  logic [CoefW-1:0] ac, bc;
  logic [ExpW-1:0]  ae, be;
  assign ia = i_r < a_cnt_r;
  assign jb = j_r < b_cnt_r;
  assign ac = ia ? a_coefs[i_r[AddrW-1:0]] : '0;
  assign ae = ia ? a_exps[i_r[AddrW-1:0]] : '0;
  assign bc = jb ? b_coefs[j_r[AddrW-1:0]] : '0;
  assign be = jb ? b_exps[j_r[AddrW-1:0]] : '0;

  logic signed [AccW-1:0] ma, mb, msum, prod;
  logic signed [31:0]     prod_w;
  assign ma     = AccW'($signed(ac));
  assign mb     = sub_r ? -AccW'($signed(bc)) : AccW'($signed(bc));
  assign msum   = ma + mb;
  assign prod_w = $signed(ac) * $signed(bc);
  assign prod   = AccW'(prod_w);

  // product chain
  prod_req_t        req;
  logic             add_en, shift_out, chain_clr;
  logic             c_valid [N+1];
  logic [AccW-1:0]  c_coef  [N+1];
  logic [PexpW-1:0] c_exp   [N+1];
  logic             c_ge    [N];
  logic             c_zero  [N];
  logic             any_hit, any_zero;

  assign c_valid[N] = 1'b0;
  assign c_coef[N]  = '0;
  assign c_exp[N]   = '0;

  always_comb begin
    any_hit  = 1'b0;
    any_zero = 1'b0;
    for (int k = 0; k < N; k++) begin
      any_hit  = any_hit | (c_valid[k] && c_exp[k] == req.exp);
      any_zero = any_zero | c_zero[k];
    end
  end
  assign req.ins  = !any_hit;
  assign req.coef = prod;
  assign req.exp  = PexpW'(ae) + PexpW'(be);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic gprev;
      assign gprev = (g == 0) ? 1'b1 : c_ge[g-1 < 0 ? 0 : g-1];
      spa_cell u_cell (
        .clk, .rst_n,
        .clr(chain_clr),
        .shift_out(shift_out),
        .add_en(add_en),
        .req(req),
        .prev_valid((g == 0) ? 1'b0 : c_valid[g-1 < 0 ? 0 : g-1]),
        .prev_coef((g == 0) ? '0 : c_coef[g-1 < 0 ? 0 : g-1]),
        .prev_exp((g == 0) ? '0 : c_exp[g-1 < 0 ? 0 : g-1]),
        .prev_ge(gprev),
        .next_valid(c_valid[g+1]),
        .next_coef(c_coef[g+1]),
        .next_exp(c_exp[g+1]),
        .next_zero_here(any_zero),
        .valid(c_valid[g]),
        .coef(c_coef[g]),
        .exp(c_exp[g]),
        .ge(c_ge[g]),
        .zero_here(c_zero[g])
      );
    end
  endgenerate

  // result outputs of one merge step
  logic                   m_emit;
  logic signed [AccW-1:0] m_coef;
  logic [PexpW-1:0]       m_exp;
  always_comb begin
    m_emit = 1'b0;
    m_coef = '0;
    m_exp  = '0;
    if (ia && (!jb || ae > be)) begin
      m_emit = 1'b1; m_coef = ma; m_exp = PexpW'(ae);
    end else if (!ia || ae < be) begin
      m_emit = 1'b1; m_coef = mb; m_exp = PexpW'(be);
    end else begin
      m_emit = msum != '0; m_coef = msum; m_exp = PexpW'(ae);
    end
  end

  // control
  always_comb begin
    st_nxt        = st_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sub_nxt       = sub_r;
    hold_vld_nxt  = hold_vld_r;
    hold_coef_nxt = hold_coef_r;
    hold_exp_nxt  = hold_exp_r;
    case (st_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        hold_vld_nxt = 1'b0;
        if (acc) begin
          case (in_opcode)
            OP_ADD, OP_SUB: begin
              sub_nxt = in_opcode == OP_SUB;
              st_nxt  = (a_cnt_r == '0 && b_cnt_r == '0) ? ST_ZERO : ST_MERGE;
            end
            OP_MUL: st_nxt = (a_cnt_r == '0 || b_cnt_r == '0) ? ST_ZERO : ST_MUL;
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MERGE: begin
        if (ia && (!jb || ae > be)) i_nxt = i_r + IdxW'(1);
        else if (!ia || ae < be) j_nxt = j_r + IdxW'(1);
        else begin
          i_nxt = i_r + IdxW'(1);
          j_nxt = j_r + IdxW'(1);
        end
        // hold the newest term until it is known whether it is the last
        if (m_emit) begin
          hold_vld_nxt  = 1'b1;
          hold_coef_nxt = m_coef;
          hold_exp_nxt  = m_exp;
        end
        if (i_nxt >= a_cnt_r && j_nxt >= b_cnt_r) st_nxt = ST_ZERO;
      end
      ST_MUL: begin
        if (j_r + IdxW'(1) >= b_cnt_r) begin
          j_nxt = '0;
          i_nxt = i_r + IdxW'(1);
          if (i_r + IdxW'(1) >= a_cnt_r) st_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (!c_valid[0] || !c_valid[1]) st_nxt = ST_IDLE;
      end
      ST_ZERO: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    add_en    = st_r == ST_MUL;
    shift_out = st_r == ST_DRAIN;
    chain_clr = acc && in_opcode == OP_MUL;
  end

  logic drain_empty;
  assign drain_empty = !c_valid[0];

  always_comb begin
    out_strobe      = 1'b0;
    out_result_coef = '0;
    out_result_exp  = '0;
    out_term_valid  = 1'b0;
    out_last_term   = 1'b0;
    out_load_error  = err_r;
    case (st_r)
      ST_MERGE: begin
        out_strobe      = m_emit && hold_vld_r;
        out_result_coef = hold_coef_r;
        out_result_exp  = hold_exp_r;
        out_term_valid  = 1'b1;
      end
      ST_DRAIN: begin
        out_strobe      = 1'b1;
        out_result_coef = drain_empty ? '0 : c_coef[0];
        out_result_exp  = drain_empty ? '0 : c_exp[0];
        out_term_valid  = !drain_empty;
        out_last_term   = drain_empty || !c_valid[1];
      end
      ST_ZERO: begin
        out_strobe      = 1'b1;
        out_result_coef = hold_vld_r ? hold_coef_r : '0;
        out_result_exp  = hold_vld_r ? hold_exp_r : '0;
        out_term_valid  = hold_vld_r;
        out_last_term   = 1'b1;
      end
      default: out_strobe = 1'b0;
    endcase
  end

  always_comb begin
    err_nxt = err_r;
    if (acc && in_opcode == OP_CLEAR) err_nxt = 1'b0;
    else if (acc && in_opcode == OP_LOAD_A && ld_bad_a) err_nxt = 1'b1;
    else if (acc && in_opcode == OP_LOAD_B && ld_bad_b) err_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      err_r       <= 1'b0;
      sub_r       <= 1'b0;
      hold_vld_r  <= 1'b0;
      hold_coef_r <= '0;
      hold_exp_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      err_r       <= err_nxt;
      sub_r       <= sub_nxt;
      hold_vld_r  <= hold_vld_nxt;
      hold_coef_r <= hold_coef_nxt;
      hold_exp_r  <= hold_exp_nxt;
      if (acc && in_opcode == OP_CLEAR) begin
        a_cnt_r <= '0;
        b_cnt_r <= '0;
      end else begin
        if (ld_a) a_cnt_r <= a_cnt_r + IdxW'(1);
        if (ld_b) b_cnt_r <= b_cnt_r + IdxW'(1);
      end
    end
  end

  a_busy_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result outside an operation");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_term) |=> !busy) else $error("busy after last term");
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_term_valid) |-> out_last_term)
    else $error("zero result not last");
endmodule

/* tb/tb_sparse_polynomial_arithmetic_unit.sv */
// Testbench for the sparse polynomial unit: directed and random requests checked against a predictor.
module tb_sparse_polynomial_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam int NTERMS = 8;
  localparam int EXPMAX = 255;

  typedef struct packed {
    logic signed [37:0] coef;
    logic [8:0]         exp;
    logic               valid;
    logic               last;
    logic               err;
  } term_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = 3'd0;
  logic signed [15:0] in_term_coef = 16'sd0;
  logic [7:0] in_term_exp = 8'd0;
  logic out_strobe;
  logic signed [37:0] out_result_coef;
  logic [8:0] out_result_exp;
  logic out_term_valid;
  logic out_last_term;
  logic out_load_error;

  logic signed [15:0] pa_coef [NTERMS];
  logic [7:0]         pa_exp  [NTERMS];
  int                 pa_cnt;
  logic signed [15:0] pb_coef [NTERMS];
  logic [7:0]         pb_exp  [NTERMS];
  int                 pb_cnt;
  logic               sticky_err;
  term_res_t          pending_terms[$];
  int                 mismatches;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sparse_polynomial_arithmetic_unit i_dut (.*);

  function automatic void push_term(logic signed [37:0] c, logic [8:0] e, logic v);
    term_res_t t;
    t.coef = c;
    t.exp = e;
    t.valid = v;
    t.last = 1'b0;
    t.err = sticky_err;
    pending_terms.push_back(t);
  endfunction

  function automatic void close_op(int before_cnt);
    term_res_t t;
    if (pending_terms.size() == before_cnt) push_term('0, '0, 1'b0);
    t = pending_terms.pop_back();
    t.last = 1'b1;
    pending_terms.push_back(t);
  endfunction

  function automatic void load_operand(bit is_b, logic signed [15:0] c, logic [7:0] e);
    int cnt;
    logic [7:0] prev;
    cnt = is_b ? pb_cnt : pa_cnt;
    prev = cnt > 0 ? (is_b ? pb_exp[cnt-1] : pa_exp[cnt-1]) : 8'd0;
    if (cnt >= NTERMS || e > EXPMAX || (cnt > 0 && e >= prev)) begin
      sticky_err = 1'b1;
      return;
    end
    if (c == 0) return;
    if (is_b) begin
      pb_coef[cnt] = c; pb_exp[cnt] = e; pb_cnt++;
    end else begin
      pa_coef[cnt] = c; pa_exp[cnt] = e; pa_cnt++;
    end
  endfunction

  function automatic void predict_merge(bit sub);
    int i, j, base;
    logic signed [37:0] c;
    i = 0; j = 0; base = pending_terms.size();
    while (i < pa_cnt || j < pb_cnt) begin
      if (j >= pb_cnt || (i < pa_cnt && pa_exp[i] > pb_exp[j])) begin
        push_term(38'(pa_coef[i]), {1'b0, pa_exp[i]}, 1'b1);
        i++;
      end else if (i >= pa_cnt || pa_exp[i] < pb_exp[j]) begin
        c = sub ? -38'(pb_coef[j]) : 38'(pb_coef[j]);
        push_term(c, {1'b0, pb_exp[j]}, 1'b1);
        j++;
      end else begin
        c = sub ? 38'(pa_coef[i]) - 38'(pb_coef[j]) : 38'(pa_coef[i]) + 38'(pb_coef[j]);
        if (c != 0) push_term(c, {1'b0, pa_exp[i]}, 1'b1);
        i++; j++;
      end
    end
    close_op(base);
  endfunction

  function automatic void predict_product();
    logic signed [37:0] pc[$];
    logic [8:0] pe[$];
    logic signed [37:0] c;
    logic [8:0] e;
    int p, base;
    base = pending_terms.size();
    for (int i = 0; i < pa_cnt; i++)
      for (int j = 0; j < pb_cnt; j++) begin
        c = 38'(pa_coef[i]) * 38'(pb_coef[j]);
        e = 9'(pa_exp[i]) + 9'(pb_exp[j]);
        p = 0;
        while (p < pc.size() && pe[p] > e) p++;
        if (p < pc.size() && pe[p] == e) begin
          pc[p] = pc[p] + c;
          if (pc[p] == 0) begin
            pc.delete(p); pe.delete(p);
          end
        end else if (pc.size() < ProdDepth) begin
          pc.insert(p, c); pe.insert(p, e);
        end
      end
    foreach (pc[k]) push_term(pc[k], pe[k], 1'b1);
    close_op(base);
  endfunction

  function automatic void predict_request(logic [2:0] op, logic signed [15:0] c, logic [7:0] e);
    case (op)
      OP_LOAD_A: load_operand(1'b0, c, e);
      OP_LOAD_B: load_operand(1'b1, c, e);
      OP_ADD:    predict_merge(1'b0);
      OP_SUB:    predict_merge(1'b1);
      OP_MUL:    predict_product();
      OP_CLEAR: begin
        pa_cnt = 0; pb_cnt = 0; sticky_err = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic signed [15:0] c, logic [7:0] e);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_term_coef <= c;
    in_term_exp <= e;
    do @(posedge clk); while (busy);
    predict_request(op, c, e);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  always @(posedge clk) begin
    term_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result coef=%0d exp=%0d",
                                       out_result_coef, out_result_exp);
      end else begin
        want = pending_terms.pop_front();
        if (want.coef !== out_result_coef || want.exp !== out_result_exp ||
            want.valid !== out_term_valid || want.last !== out_last_term ||
            want.err !== out_load_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp c=%0d e=%0d v=%b l=%b x=%b got c=%0d e=%0d v=%b l=%b x=%b",
                     want.coef, want.exp, want.valid, want.last, want.err,
                     out_result_coef, out_result_exp, out_term_valid, out_last_term,
                     out_load_error);
        end
      end
    end
  end

  task automatic run_ops();
    send_request(OP_ADD, 0, 0);
    send_request(OP_SUB, 0, 0);
    send_request(OP_MUL, 0, 0);
  endtask

  task automatic test_directed();
    send_request(OP_LOAD_A, 16'sh7FFF, 8'd255);
    send_request(OP_LOAD_A, 16'sh8000, 8'd128);
    send_request(OP_LOAD_A, 16'sd0, 8'd100);
    send_request(OP_LOAD_A, 16'sd5, 8'd0);
    send_request(OP_LOAD_B, 16'sh8000, 8'd255);
    send_request(OP_LOAD_B, -16'sd5, 8'd128);
    send_request(OP_LOAD_B, 16'sd3, 8'd1);
    send_request(OP_LOAD_B, 16'sd3, 8'd1);
    run_ops();
    send_request(3'd6, 16'sh5555, 8'hAA);
    send_request(3'd7, 16'shAAAA, 8'h55);
    send_request(OP_CLEAR, 0, 0);
    run_ops();
    for (int k = 0; k < 9; k++) send_request(OP_LOAD_A, 16'sh8000, 8'(200 - k));
    send_request(OP_LOAD_B, 16'sh8000, 8'd7);
    send_request(OP_MUL, 0, 0);
    wait_drain();
  endtask

  task automatic test_cancel();
    send_request(OP_CLEAR, 0, 0);
    send_request(OP_LOAD_A, 16'sd4, 8'd9);
    send_request(OP_LOAD_A, -16'sd4, 8'd3);
    send_request(OP_LOAD_B, 16'sd4, 8'd9);
    send_request(OP_LOAD_B, 16'sd4, 8'd3);
    send_request(OP_SUB, 0, 0);
    send_request(OP_LOAD_B, 16'sd1, 8'd6);
    send_request(OP_MUL, 0, 0);
  endtask

  task automatic test_random();
    int sent;
    int na, nb;
    logic [7:0] e;
    sent = 0;
    while (sent < 180) begin
      send_request(OP_CLEAR, 0, 0);
      na = $urandom_range(0, 8);
      nb = $urandom_range(0, 8);
      e = 8'($urandom_range(8, 255));
      for (int k = 0; k < na; k++) begin
        send_request(OP_LOAD_A, 16'($urandom), e);
        e = e - 8'($urandom_range(1, 3));
      end
      e = 8'($urandom_range(8, 255));
      for (int k = 0; k < nb; k++) begin
        send_request(OP_LOAD_B, $urandom_range(0, 1) ? 16'($urandom)
                     : 16'(pa_coef[$urandom_range(0, NTERMS - 1)]), e);
        e = e - 8'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 4) == 0)
        send_request(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
      run_ops();
      sent += na + nb + 4;
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
  endtask

  initial begin
    mismatches = 0;
    pa_cnt = 0;
    pb_cnt = 0;
    sticky_err = 1'b0;
    foreach (pa_coef[k]) begin
      pa_coef[k] = 0; pa_exp[k] = 0; pb_coef[k] = 0; pb_exp[k] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cancel();
    test_random();
    wait_drain();
    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
